[rtl/core/srgb_to_lab_converter_macros.svh]
// Assertion macros shared by the sRGB to CIELAB converter RTL.
// Depends on the including module having clk and rst_n in scope.
`ifndef SRGB_TO_LAB_CONVERTER_MACROS_SVH
`define SRGB_TO_LAB_CONVERTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define S2L_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s2l assertion failed");

// Next-cycle implication, checked out of reset.
`define S2L_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s2l assertion failed");

`endif

[rtl/core/s2l_pkg.sv]
// Types, constants and the gamma table for the sRGB to CIELAB converter.
// No dependencies.
`timescale 1ns / 1ps

package s2l_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_pix_t;

  typedef struct packed {
    logic        [14:0] lightness;
    logic signed [15:0] green_red_axis;
    logic signed [15:0] blue_yellow_axis;
  } out_lab_t;

  localparam int LIN_W  = 17;   // Q1.16 linear value, up to 1.0
  localparam int COEF_W = 20;   // Q0.20 matrix coefficient
  localparam int PROD_W = LIN_W + COEF_W;
  localparam int ACC_W  = PROD_W + 2;

  // Steps of the cube root: 17 result bits plus one rounding step.
  localparam int ROOT_STEPS = 18;
  localparam int F_LAT      = ROOT_STEPS + 1;
  // gamma, products, matrix sum, f(), Lab products, round and saturate
  localparam int PIPE_LAT   = 3 + F_LAT + 2;

  // Linear segment: f = (LIN_MUL * v + LIN_ADD) / 29000, for v <= SEG_MAX.
  // Take it as ((num >> LIN_SHR) * LIN_RECIP) >> LIN_RSH, exact for num < 2^29.
  localparam int SEG_MAX   = 580;
  localparam int LIN_MUL   = 225823;
  localparam int LIN_ADD   = 262158500;
  localparam int LIN_SHR   = 3;
  localparam int LIN_RECIP = 75828389;
  localparam int RECIP_W   = 27;
  localparam int LIN_RSH   = 38;
  localparam int QUO_W     = 14;

  typedef logic [COEF_W-1:0] coef_row_t [3];
  localparam coef_row_t MAT_Q20 [3] = '{
    '{20'd455029, 20'd394485, 20'd199062},
    '{20'd223004, 20'd749891, 20'd75681},
    '{20'd18619,  20'd114786, 20'd915171}
  };

  // Unsigned 64-bit division, shift and subtract.
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo, rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [LIN_W-1:0] gamma_entry(input int unsigned i);
    longint unsigned t, s, r, r2, r4, q, nr, v;
    longint unsigned half;
    bit done;
    half = 64'd1 << 27;
    if (i <= 10) begin
      v = (longint'(i) * 64'd655360 + 64'd16473) / 64'd32946;
    end else begin
      t = ((((longint'(1000 * i + 14025)) << 29) / 64'd269025) + 64'd1) >> 1;
      s = (t * t + half) >> 28;
      r = 64'd1 << 28;
      done = 1'b0;
      for (int k = 0; k < 64; k++) begin
        if (!done) begin
          r2 = (r * r + half) >> 28;
          r4 = (r2 * r2 + half) >> 28;
          if (r4 == 0) begin
            done = 1'b1;
          end else begin
            q  = div_u64(s << 28, r4);
            nr = (64'd4 * r + q) / 64'd5;
            if (nr >= r) done = 1'b1;
            else r = nr;
          end
        end
      end
      v = (s * r + (64'd1 << 39)) >> 40;
      if (v > 64'd65536) v = 64'd65536;
    end
    return LIN_W'(v);
  endfunction

  typedef logic [LIN_W-1:0] gamma_lut_t [256];

  function automatic gamma_lut_t build_gamma();
    gamma_lut_t lut;
    for (int i = 0; i < 256; i++) lut[i] = gamma_entry(i);
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma();

endpackage

[rtl/core/srgb_to_lab_converter.sv]
// sRGB to CIELAB (D65) converter, top level: valid/ready pixel stream.
// Depends on s2l_pkg, s2l_lab_f and srgb_to_lab_converter_macros.svh.
`timescale 1ns / 1ps
`include "srgb_to_lab_converter_macros.svh"

// One 8-bit sRGB pixel in, one CIELAB result (L, a, b in Q8) out. The block
// is a 24-stage pipeline that takes a new item every clock while the output
// side keeps up, so sustained throughput is one pixel per cycle. Most of the
// depth is the cube root, which resolves one result bit per stage (17 bits
// plus a rounding step); gamma lookup, the 3x3 matrix and the final Lab
// scaling take the remaining stages. While a result waits at the output and
// out_ready is low, the whole pipeline holds, so nothing is lost or repeated;
// in_ready is low only while a finished result sits unclaimed at the output.
module srgb_to_lab_converter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  s2l_pkg::in_pix_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output s2l_pkg::out_lab_t out_data
);

  localparam int LAT   = s2l_pkg::PIPE_LAT;
  localparam int LIN_W = s2l_pkg::LIN_W;

  logic                        ce;
  logic [LAT-1:0]              vld_r;
  logic [LIN_W-1:0]            lin_r  [3];
  logic [s2l_pkg::PROD_W-1:0]  prod_r [3][3];
  logic [s2l_pkg::ACC_W-1:0]   acc_w  [3];
  logic [LIN_W-1:0]            xyz_r  [3];
  logic [LIN_W-1:0]            f_w    [3];

  logic signed [25:0] l_r, l_nxt;
  logic signed [27:0] a_r, a_nxt;
  logic signed [27:0] b_r, b_nxt;
  logic signed [17:0] dxy, dyz;
  logic [23:0]        l_prod;
  logic signed [25:0] l_rnd;
  logic signed [27:0] a_rnd, b_rnd;
  s2l_pkg::out_lab_t  out_r, out_nxt;

  // advance everything unless a result waits at the output and out_ready is low
  assign ce       = !vld_r[LAT-1] || out_ready;
  assign in_ready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // matrix row sums, rounded from Q1.36 back to Q1.16
  always_comb begin
    for (int row = 0; row < 3; row++) begin
      acc_w[row] = s2l_pkg::ACC_W'(prod_r[row][0]) + s2l_pkg::ACC_W'(prod_r[row][1])
                 + s2l_pkg::ACC_W'(prod_r[row][2]) + (s2l_pkg::ACC_W'(1) << 19);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      lin_r[0] <= s2l_pkg::GAMMA_LUT[in_data.red];
      lin_r[1] <= s2l_pkg::GAMMA_LUT[in_data.green];
      lin_r[2] <= s2l_pkg::GAMMA_LUT[in_data.blue];
      for (int row = 0; row < 3; row++) begin
        for (int col = 0; col < 3; col++) begin
          prod_r[row][col] <= s2l_pkg::PROD_W'(lin_r[col])
                            * s2l_pkg::PROD_W'(s2l_pkg::MAT_Q20[row][col]);
        end
        xyz_r[row] <= acc_w[row][LIN_W+19:20];
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_f
    s2l_lab_f u_f (
      .clk (clk),
      .ce  (ce),
      .v   (xyz_r[ch]),
      .f   (f_w[ch])
    );
  end

  // Lab scaling in Q16: L = 116 fy - 16, a = 500 (fx - fy), b = 200 (fy - fz)
  always_comb begin
    l_prod = 24'(f_w[1]) * 24'd116;
    l_nxt  = $signed({2'b00, l_prod}) - 26'sd1048576;
    dxy    = $signed({1'b0, f_w[0]}) - $signed({1'b0, f_w[1]});
    dyz    = $signed({1'b0, f_w[1]}) - $signed({1'b0, f_w[2]});
    a_nxt  = 28'(dxy) * 28'sd500;
    b_nxt  = 28'(dyz) * 28'sd200;
  end

  // round to Q8 (ties up), then saturate
  always_comb begin
    l_rnd = (l_r + 26'sd128) >>> 8;
    a_rnd = (a_r + 28'sd128) >>> 8;
    b_rnd = (b_r + 28'sd128) >>> 8;
    if (l_rnd < 0)               out_nxt.lightness = '0;
    else if (l_rnd > 26'sd25600) out_nxt.lightness = 15'd25600;
    else                         out_nxt.lightness = l_rnd[14:0];
    if (a_rnd < -28'sd32768)     out_nxt.green_red_axis = -16'sd32768;
    else if (a_rnd > 28'sd32767) out_nxt.green_red_axis = 16'sd32767;
    else                         out_nxt.green_red_axis = a_rnd[15:0];
    if (b_rnd < -28'sd32768)     out_nxt.blue_yellow_axis = -16'sd32768;
    else if (b_rnd > 28'sd32767) out_nxt.blue_yellow_axis = 16'sd32767;
    else                         out_nxt.blue_yellow_axis = b_rnd[15:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      l_r   <= l_nxt;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

  // an accepted item shows up in the first stage
  `S2L_ASSERT_NXT(a_accept_enters, in_valid && in_ready, vld_r[0])
  // a stall freezes every valid bit
  `S2L_ASSERT_NXT(a_stall_holds, !ce, $stable(vld_r))
  // lightness never leaves its range
  `S2L_ASSERT_IMP(a_l_range, out_valid, out_data.lightness <= 15'd25600)
  // f() stays within 0..1.0 in Q1.16 for live items
  `S2L_ASSERT_IMP(a_f_range, vld_r[LAT-3],
                  f_w[0] <= 17'd65536 && f_w[1] <= 17'd65536 && f_w[2] <= 17'd65536)

endmodule

[rtl/core/s2l_lab_f.sv]
// Pipelined CIELAB f(): digit-serial cube root, one bit per stage, with a
// reciprocal-multiply linear segment running alongside. Uses s2l_pkg.
`timescale 1ns / 1ps

module s2l_lab_f (
  input  logic                       clk,
  input  logic                       ce,
  input  logic [s2l_pkg::LIN_W-1:0]  v,
  output logic [s2l_pkg::LIN_W-1:0]  f
);

  localparam int STEPS = s2l_pkg::ROOT_STEPS;
  localparam int YW    = STEPS;
  localparam int Y2W   = 2 * YW;
  localparam int RW    = Y2W + 4;
  localparam int NW    = 3 * STEPS;
  localparam int QW    = s2l_pkg::QUO_W;
  localparam int NUMW  = 29;
  localparam int DW    = NUMW - s2l_pkg::LIN_SHR;
  localparam int PW    = DW + s2l_pkg::RECIP_W;

  logic [YW-1:0]   y_r   [STEPS];
  logic [Y2W-1:0]  y2_r  [STEPS];
  logic [RW-1:0]   rem_r [STEPS];
  logic [NW-1:0]   n_r   [STEPS];
  logic            seg_r [STEPS];

  logic [YW-1:0]   y_nxt   [STEPS];
  logic [Y2W-1:0]  y2_nxt  [STEPS];
  logic [RW-1:0]   rem_nxt [STEPS];
  logic [NW-1:0]   n_nxt   [STEPS];
  logic            seg_nxt [STEPS];

  logic [YW-1:0]   y_in   [STEPS];
  logic [Y2W-1:0]  y2_in  [STEPS];
  logic [RW-1:0]   rem_in [STEPS];
  logic [NW-1:0]   n_in   [STEPS];
  logic            seg_in [STEPS];
  logic [RW-1:0]   r8_w   [STEPS];
  logic [RW-1:0]   t_w    [STEPS];

  // linear segment: numerator in the first stage, quotient in the second
  logic [NUMW-1:0] num_w, num_r;
  logic [PW-1:0]   quo_prod;
  logic [QW-1:0]   q_r [STEPS-1];

  logic [s2l_pkg::LIN_W-1:0] f_r;
  logic [YW:0]               y_rnd;

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      if (k == 0) begin
        y_in[k]   = '0;
        y2_in[k]  = '0;
        rem_in[k] = '0;
        // radicand 8 * v * 2^32, grouped in 3-bit digits
        n_in[k]   = {2'b00, v, 35'd0};
        seg_in[k] = (v <= s2l_pkg::LIN_W'(s2l_pkg::SEG_MAX));
      end else begin
        y_in[k]   = y_r[k-1];
        y2_in[k]  = y2_r[k-1];
        rem_in[k] = rem_r[k-1];
        n_in[k]   = n_r[k-1];
        seg_in[k] = seg_r[k-1];
      end
      // cube root digit: try y -> 2y+1, cost 12y^2 + 6y + 1
      r8_w[k] = {rem_in[k][RW-4:0], n_in[k][NW-1 -: 3]};
      t_w[k]  = ({4'b0, y2_in[k]} << 3) + ({4'b0, y2_in[k]} << 2)
              + (RW'(y_in[k]) << 2) + (RW'(y_in[k]) << 1) + RW'(1);
      n_nxt[k] = n_in[k] << 3;
      if (r8_w[k] >= t_w[k]) begin
        rem_nxt[k] = r8_w[k] - t_w[k];
        y_nxt[k]   = {y_in[k][YW-2:0], 1'b1};
        y2_nxt[k]  = (y2_in[k] << 2) + (Y2W'(y_in[k]) << 2) + Y2W'(1);
      end else begin
        rem_nxt[k] = r8_w[k];
        y_nxt[k]   = {y_in[k][YW-2:0], 1'b0};
        y2_nxt[k]  = y2_in[k] << 2;
      end
      seg_nxt[k] = seg_in[k];
    end
  end

  assign num_w    = NUMW'(s2l_pkg::LIN_MUL) * NUMW'(v[9:0]) + NUMW'(s2l_pkg::LIN_ADD);
  assign quo_prod = PW'(num_r[NUMW-1:s2l_pkg::LIN_SHR]) * PW'(s2l_pkg::LIN_RECIP);

  // last step decided the rounding bit: root = floor(cbrt(8n)) / 2, rounded
  assign y_rnd = {1'b0, y_r[STEPS-1]} + (YW+1)'(1);

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < STEPS; k++) begin
        y_r[k]   <= y_nxt[k];
        y2_r[k]  <= y2_nxt[k];
        rem_r[k] <= rem_nxt[k];
        n_r[k]   <= n_nxt[k];
        seg_r[k] <= seg_nxt[k];
      end
      num_r  <= num_w;
      q_r[0] <= quo_prod[s2l_pkg::LIN_RSH +: QW];
      for (int j = 1; j < STEPS - 1; j++) begin
        q_r[j] <= q_r[j-1];
      end
      f_r <= seg_r[STEPS-1] ? s2l_pkg::LIN_W'(q_r[STEPS-2])
                            : y_rnd[s2l_pkg::LIN_W:1];
    end
  end

  assign f = f_r;

endmodule
